/* rtl/rsub_pkg.sv */
// Shared types, register map and piece table for the rectangle subtract block.
`default_nettype none

package rsub_pkg;

  // Default coordinate width; sizes are one bit narrower
  localparam int unsigned COORD_WIDTH_DEF = 16;

  // Front-to-back queue depth
  localparam int unsigned QUEUE_DEPTH = 4;

  // Configuration port geometry
  localparam int unsigned APB_DATA_WIDTH = 32;
  localparam int unsigned APB_ADDR_WIDTH = 4;

  // Register indexes (byte address = 4 * index)
  localparam logic [1:0] REG_CLIP_X      = 2'd0;
  localparam logic [1:0] REG_CLIP_Y      = 2'd1;
  localparam logic [1:0] REG_CLIP_WIDTH  = 2'd2;
  localparam logic [1:0] REG_CLIP_HEIGHT = 2'd3;

  // Where the clip span lies relative to the item span on one axis
  typedef enum logic [2:0] {
    CLS_BEFORE,
    CLS_LEAD,
    CLS_COVER,
    CLS_MID,
    CLS_TRAIL,
    CLS_AFTER
  } cls_e;

  // Source of a piece's left edge
  typedef enum logic [1:0] {
    X_AX0,
    X_BX0,
    X_BX1,
    X_ZERO
  } xsel_e;

  // Source of a piece's top edge
  typedef enum logic [1:0] {
    Y_AY0,
    Y_BY0,
    Y_BY1,
    Y_ZERO
  } ysel_e;

  // Source of a piece's width
  typedef enum logic [2:0] {
    W_AW,     // a_width
    W_LEFT,   // bx0 - ax0
    W_RIGHT,  // ax1 - bx1
    W_BW,     // clip_width
    W_ZERO
  } wsel_e;

  // Source of a piece's height
  typedef enum logic [2:0] {
    H_AH,     // a_height
    H_TOP,    // by0 - ay0
    H_BOTTOM, // ay1 - by1
    H_UPPER,  // by1 - ay0
    H_LOWER,  // ay1 - by0
    H_BH,     // clip_height
    H_ZERO
  } hsel_e;

  // One row of the piece table
  typedef struct packed {
    xsel_e xs;
    ysel_e ys;
    wsel_e ws;
    hsel_e hs;
    logic  last;
  } piece_sel_t;

  // Per-item control carried from front to back
  typedef struct packed {
    cls_e xc;
    cls_e yc;
    logic list_cut;
  } item_ctrl_t;

  // Per-piece flags carried to the result ports
  typedef struct packed {
    logic piece_valid;
    logic item_cut;
    logic last_piece;
    logic list_cut;
  } piece_flags_t;

  function automatic piece_sel_t mk(xsel_e xs, ysel_e ys, wsel_e ws, hsel_e hs, logic last);
    piece_sel_t p;
    p.xs   = xs;
    p.ys   = ys;
    p.ws   = ws;
    p.hs   = hs;
    p.last = last;
    return p;
  endfunction

  // B overlaps A on both axes
  function automatic logic is_cut(cls_e xc, cls_e yc);
    return (xc != CLS_BEFORE) && (xc != CLS_AFTER) && (yc != CLS_BEFORE) && (yc != CLS_AFTER);
  endfunction

  // A survives unless B covers it on both axes
  function automatic logic is_valid(cls_e xc, cls_e yc);
    return !((xc == CLS_COVER) && (yc == CLS_COVER));
  endfunction

  // Piece k of the overlap case (xc, yc), in emission order
  function automatic piece_sel_t piece_sel(cls_e xc, cls_e yc, logic [1:0] k);
    piece_sel_t p;
    p = mk(X_AX0, Y_AY0, W_AW, H_AH, 1'b1);
    case ({xc, yc})
      {CLS_TRAIL, CLS_TRAIL}: begin
        case (k)
          2'd0:    p = mk(X_AX0, Y_AY0, W_AW, H_TOP, 1'b0);
          default: p = mk(X_AX0, Y_BY0, W_LEFT, H_LOWER, 1'b1);
        endcase
      end
      {CLS_TRAIL, CLS_LEAD}: begin
        case (k)
          2'd0:    p = mk(X_AX0, Y_AY0, W_LEFT, H_UPPER, 1'b0);
          default: p = mk(X_AX0, Y_BY1, W_AW, H_BOTTOM, 1'b1);
        endcase
      end
      {CLS_LEAD, CLS_LEAD}: begin
        case (k)
          2'd0:    p = mk(X_BX1, Y_AY0, W_RIGHT, H_UPPER, 1'b0);
          default: p = mk(X_AX0, Y_BY1, W_AW, H_BOTTOM, 1'b1);
        endcase
      end
      {CLS_LEAD, CLS_TRAIL}: begin
        case (k)
          2'd0:    p = mk(X_AX0, Y_AY0, W_AW, H_TOP, 1'b0);
          default: p = mk(X_BX1, Y_BY0, W_RIGHT, H_LOWER, 1'b1);
        endcase
      end
      {CLS_TRAIL, CLS_MID}: begin
        case (k)
          2'd0:    p = mk(X_AX0, Y_AY0, W_AW, H_TOP, 1'b0);
          2'd1:    p = mk(X_AX0, Y_BY0, W_LEFT, H_BH, 1'b0);
          default: p = mk(X_AX0, Y_BY1, W_AW, H_BOTTOM, 1'b1);
        endcase
      end
      {CLS_MID, CLS_LEAD}: begin
        case (k)
          2'd0:    p = mk(X_AX0, Y_AY0, W_LEFT, H_AH, 1'b0);
          2'd1:    p = mk(X_BX0, Y_BY1, W_BW, H_BOTTOM, 1'b0);
          default: p = mk(X_BX1, Y_AY0, W_RIGHT, H_AH, 1'b1);
        endcase
      end
      {CLS_LEAD, CLS_MID}: begin
        case (k)
          2'd0:    p = mk(X_AX0, Y_AY0, W_AW, H_TOP, 1'b0);
          2'd1:    p = mk(X_BX1, Y_BY0, W_RIGHT, H_BH, 1'b0);
          default: p = mk(X_AX0, Y_BY1, W_AW, H_BOTTOM, 1'b1);
        endcase
      end
      {CLS_MID, CLS_TRAIL}: begin
        case (k)
          2'd0:    p = mk(X_AX0, Y_AY0, W_LEFT, H_AH, 1'b0);
          2'd1:    p = mk(X_BX0, Y_AY0, W_BW, H_TOP, 1'b0);
          default: p = mk(X_BX1, Y_AY0, W_RIGHT, H_AH, 1'b1);
        endcase
      end
      {CLS_TRAIL, CLS_COVER}: p = mk(X_AX0, Y_AY0, W_LEFT, H_AH, 1'b1);
      {CLS_COVER, CLS_LEAD}:  p = mk(X_AX0, Y_BY1, W_AW, H_BOTTOM, 1'b1);
      {CLS_LEAD, CLS_COVER}:  p = mk(X_BX1, Y_AY0, W_RIGHT, H_AH, 1'b1);
      {CLS_COVER, CLS_TRAIL}: p = mk(X_AX0, Y_AY0, W_AW, H_TOP, 1'b1);
      {CLS_COVER, CLS_MID}: begin
        case (k)
          2'd0:    p = mk(X_AX0, Y_AY0, W_AW, H_TOP, 1'b0);
          default: p = mk(X_AX0, Y_BY1, W_AW, H_BOTTOM, 1'b1);
        endcase
      end
      {CLS_MID, CLS_COVER}: begin
        case (k)
          2'd0:    p = mk(X_AX0, Y_AY0, W_LEFT, H_AH, 1'b0);
          default: p = mk(X_BX1, Y_AY0, W_RIGHT, H_AH, 1'b1);
        endcase
      end
      {CLS_COVER, CLS_COVER}: p = mk(X_ZERO, Y_ZERO, W_ZERO, H_ZERO, 1'b1);
      {CLS_MID, CLS_MID}: begin
        case (k)
          2'd0:    p = mk(X_AX0, Y_AY0, W_AW, H_TOP, 1'b0);
          2'd1:    p = mk(X_AX0, Y_BY0, W_LEFT, H_BH, 1'b0);
          2'd2:    p = mk(X_BX1, Y_BY0, W_RIGHT, H_BH, 1'b0);
          default: p = mk(X_AX0, Y_BY1, W_AW, H_BOTTOM, 1'b1);
        endcase
      end
      default: p = mk(X_AX0, Y_AY0, W_AW, H_AH, 1'b1);
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

/* rtl/rsub_front.sv */
// Front end: classify each rectangle against the clip box and queue it for the back end.
`default_nettype none

module rsub_front #(
  parameter int unsigned COORD_WIDTH = rsub_pkg::COORD_WIDTH_DEF
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  // clip box
  input  wire logic [COORD_WIDTH-1:0]   clip_x_i,
  input  wire logic [COORD_WIDTH-1:0]   clip_y_i,
  input  wire logic [COORD_WIDTH-2:0]   clip_width_i,
  input  wire logic [COORD_WIDTH-2:0]   clip_height_i,
  // item intake
  input  wire logic                     push_i,
  output logic                          full_o,
  input  wire logic [COORD_WIDTH-1:0]   a_x_i,
  input  wire logic [COORD_WIDTH-1:0]   a_y_i,
  input  wire logic [COORD_WIDTH-2:0]   a_width_i,
  input  wire logic [COORD_WIDTH-2:0]   a_height_i,
  input  wire logic                     end_of_list_i,
  // queue head toward the back end
  output logic                          hd_valid_o,
  input  wire logic                     hd_take_i,
  output logic [COORD_WIDTH-1:0]        hd_ax0_o,
  output logic [COORD_WIDTH-1:0]        hd_ay0_o,
  output logic [COORD_WIDTH-2:0]        hd_aw_o,
  output logic [COORD_WIDTH-2:0]        hd_ah_o,
  output logic [COORD_WIDTH-2:0]        hd_left_o,
  output logic [COORD_WIDTH-2:0]        hd_right_o,
  output logic [COORD_WIDTH-2:0]        hd_top_o,
  output logic [COORD_WIDTH-2:0]        hd_bottom_o,
  output logic [COORD_WIDTH-2:0]        hd_upper_o,
  output logic [COORD_WIDTH-2:0]        hd_lower_o,
  output rsub_pkg::item_ctrl_t          hd_ctrl_o
);

  localparam int unsigned W   = COORD_WIDTH;
  localparam int unsigned SW  = COORD_WIDTH - 1;
  localparam int unsigned QD  = rsub_pkg::QUEUE_DEPTH;
  localparam int unsigned PW  = $clog2(QD);
  localparam int unsigned CW  = $clog2(QD + 1);

  function automatic rsub_pkg::cls_e classify(
    input logic signed [W:0] a0,
    input logic signed [W:0] a1,
    input logic signed [W:0] b0,
    input logic signed [W:0] b1
  );
    rsub_pkg::cls_e c;
    if (b0 <= a0) begin
      if (b1 <= a0) begin
        c = rsub_pkg::CLS_BEFORE;
      end else if (b1 < a1) begin
        c = rsub_pkg::CLS_LEAD;
      end else begin
        c = rsub_pkg::CLS_COVER;
      end
    end else if (b0 < a1) begin
      c = (b1 < a1) ? rsub_pkg::CLS_MID : rsub_pkg::CLS_TRAIL;
    end else begin
      c = rsub_pkg::CLS_AFTER;
    end
    return c;
  endfunction

  logic signed [W:0]    ax0, ax1, ay0, ay1, bx0, bx1, by0, by1;
  logic [SW-1:0]        left, right, top, bottom, upper, lower;
  rsub_pkg::cls_e       xc, yc;
  logic                 cut;
  rsub_pkg::item_ctrl_t ctrl;
  logic                 wr_en, rd_en;
  logic                 seen_q, seen_d;
  logic [PW-1:0]        wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]        cnt_q;

  logic [W-1:0]         q_ax0 [QD];
  logic [W-1:0]         q_ay0 [QD];
  logic [SW-1:0]        q_aw [QD];
  logic [SW-1:0]        q_ah [QD];
  logic [SW-1:0]        q_left [QD];
  logic [SW-1:0]        q_right [QD];
  logic [SW-1:0]        q_top [QD];
  logic [SW-1:0]        q_bottom [QD];
  logic [SW-1:0]        q_upper [QD];
  logic [SW-1:0]        q_lower [QD];
  rsub_pkg::item_ctrl_t q_ctrl [QD];

  // Span ends with one guard bit so the compares see the true values
  always_comb begin
    ax0 = {a_x_i[W-1], a_x_i};
    ay0 = {a_y_i[W-1], a_y_i};
    bx0 = {clip_x_i[W-1], clip_x_i};
    by0 = {clip_y_i[W-1], clip_y_i};
    ax1 = ax0 + {2'b00, a_width_i};
    ay1 = ay0 + {2'b00, a_height_i};
    bx1 = bx0 + {2'b00, clip_width_i};
    by1 = by0 + {2'b00, clip_height_i};
  end

  // Leftover strip sizes, wrapped to the size width
  always_comb begin
    left   = bx0[SW-1:0] - ax0[SW-1:0];
    right  = ax1[SW-1:0] - bx1[SW-1:0];
    top    = by0[SW-1:0] - ay0[SW-1:0];
    bottom = ay1[SW-1:0] - by1[SW-1:0];
    upper  = by1[SW-1:0] - ay0[SW-1:0];
    lower  = ay1[SW-1:0] - by0[SW-1:0];
  end

  // Classify both axes and fold the cut flag into the list
  always_comb begin
    xc            = classify(ax0, ax1, bx0, bx1);
    yc            = classify(ay0, ay1, by0, by1);
    cut           = rsub_pkg::is_cut(xc, yc);
    ctrl.xc       = xc;
    ctrl.yc       = yc;
    ctrl.list_cut = end_of_list_i & (seen_q | cut);
    seen_d        = end_of_list_i ? 1'b0 : (seen_q | cut);
  end

  assign full_o     = (cnt_q == CW'(QD));
  assign hd_valid_o = (cnt_q != '0);
  assign wr_en      = push_i & ~full_o;
  assign rd_en      = hd_take_i & hd_valid_o;

  // Advance pointers, count and list state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
      seen_q   <= 1'b0;
    end else begin
      if (wr_en) begin
        wr_ptr_q <= wr_ptr_q + PW'(1);
        seen_q   <= seen_d;
      end
      if (rd_en) begin
        rd_ptr_q <= rd_ptr_q + PW'(1);
      end
      if (wr_en && !rd_en) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (rd_en && !wr_en) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

  // Store the classified item
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      q_ax0[wr_ptr_q]    <= a_x_i;
      q_ay0[wr_ptr_q]    <= a_y_i;
      q_aw[wr_ptr_q]     <= a_width_i;
      q_ah[wr_ptr_q]     <= a_height_i;
      q_left[wr_ptr_q]   <= left;
      q_right[wr_ptr_q]  <= right;
      q_top[wr_ptr_q]    <= top;
      q_bottom[wr_ptr_q] <= bottom;
      q_upper[wr_ptr_q]  <= upper;
      q_lower[wr_ptr_q]  <= lower;
      q_ctrl[wr_ptr_q]   <= ctrl;
    end
  end

  // Present the oldest item
  assign hd_ax0_o    = q_ax0[rd_ptr_q];
  assign hd_ay0_o    = q_ay0[rd_ptr_q];
  assign hd_aw_o     = q_aw[rd_ptr_q];
  assign hd_ah_o     = q_ah[rd_ptr_q];
  assign hd_left_o   = q_left[rd_ptr_q];
  assign hd_right_o  = q_right[rd_ptr_q];
  assign hd_top_o    = q_top[rd_ptr_q];
  assign hd_bottom_o = q_bottom[rd_ptr_q];
  assign hd_upper_o  = q_upper[rd_ptr_q];
  assign hd_lower_o  = q_lower[rd_ptr_q];
  assign hd_ctrl_o   = q_ctrl[rd_ptr_q];

endmodule

`default_nettype wire

/* rtl/rsub_back.sv */
// Back end: walk the piece table of the head item and buffer one piece per cycle while the result buffer has room.
`default_nettype none

module rsub_back #(
  parameter int unsigned COORD_WIDTH = rsub_pkg::COORD_WIDTH_DEF
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  // clip box
  input  wire logic [COORD_WIDTH-1:0] clip_x_i,
  input  wire logic [COORD_WIDTH-1:0] clip_y_i,
  input  wire logic [COORD_WIDTH-2:0] clip_width_i,
  input  wire logic [COORD_WIDTH-2:0] clip_height_i,
  // queue head from the front end
  input  wire logic                   hd_valid_i,
  output logic                        hd_take_o,
  input  wire logic [COORD_WIDTH-1:0] hd_ax0_i,
  input  wire logic [COORD_WIDTH-1:0] hd_ay0_i,
  input  wire logic [COORD_WIDTH-2:0] hd_aw_i,
  input  wire logic [COORD_WIDTH-2:0] hd_ah_i,
  input  wire logic [COORD_WIDTH-2:0] hd_left_i,
  input  wire logic [COORD_WIDTH-2:0] hd_right_i,
  input  wire logic [COORD_WIDTH-2:0] hd_top_i,
  input  wire logic [COORD_WIDTH-2:0] hd_bottom_i,
  input  wire logic [COORD_WIDTH-2:0] hd_upper_i,
  input  wire logic [COORD_WIDTH-2:0] hd_lower_i,
  input  wire rsub_pkg::item_ctrl_t   hd_ctrl_i,
  // result queue
  output logic                        empty_o,
  input  wire logic                   pop_i,
  output logic [COORD_WIDTH-1:0]      piece_x_o,
  output logic [COORD_WIDTH-1:0]      piece_y_o,
  output logic [COORD_WIDTH-2:0]      piece_width_o,
  output logic [COORD_WIDTH-2:0]      piece_height_o,
  output logic                        piece_valid_o,
  output logic                        item_cut_o,
  output logic                        last_piece_o,
  output logic                        list_cut_o
);

  localparam int unsigned W  = COORD_WIDTH;
  localparam int unsigned SW = COORD_WIDTH - 1;

  rsub_pkg::piece_sel_t   sel;
  rsub_pkg::piece_flags_t flags;
  logic [W-1:0]           bx1, by1, px, py;
  logic [SW-1:0]          pw, ph;
  logic [1:0]             k_q;
  logic                   step;
  logic                   o_wr, o_rd;
  logic                   o_wr_ptr_q, o_rd_ptr_q;
  logic [1:0]             o_cnt_q;

  logic [W-1:0]           o_x [2];
  logic [W-1:0]           o_y [2];
  logic [SW-1:0]          o_w [2];
  logic [SW-1:0]          o_h [2];
  rsub_pkg::piece_flags_t o_flags [2];

  assign bx1 = clip_x_i + {1'b0, clip_width_i};
  assign by1 = clip_y_i + {1'b0, clip_height_i};

  // Look up the current piece and pick its edges and sizes
  always_comb begin
    sel = rsub_pkg::piece_sel(hd_ctrl_i.xc, hd_ctrl_i.yc, k_q);
    case (sel.xs)
      rsub_pkg::X_AX0: px = hd_ax0_i;
      rsub_pkg::X_BX0: px = clip_x_i;
      rsub_pkg::X_BX1: px = bx1;
      default:         px = '0;
    endcase
    case (sel.ys)
      rsub_pkg::Y_AY0: py = hd_ay0_i;
      rsub_pkg::Y_BY0: py = clip_y_i;
      rsub_pkg::Y_BY1: py = by1;
      default:         py = '0;
    endcase
    case (sel.ws)
      rsub_pkg::W_AW:    pw = hd_aw_i;
      rsub_pkg::W_LEFT:  pw = hd_left_i;
      rsub_pkg::W_RIGHT: pw = hd_right_i;
      rsub_pkg::W_BW:    pw = clip_width_i;
      default:           pw = '0;
    endcase
    case (sel.hs)
      rsub_pkg::H_AH:     ph = hd_ah_i;
      rsub_pkg::H_TOP:    ph = hd_top_i;
      rsub_pkg::H_BOTTOM: ph = hd_bottom_i;
      rsub_pkg::H_UPPER:  ph = hd_upper_i;
      rsub_pkg::H_LOWER:  ph = hd_lower_i;
      rsub_pkg::H_BH:     ph = clip_height_i;
      default:            ph = '0;
    endcase
    flags.piece_valid = rsub_pkg::is_valid(hd_ctrl_i.xc, hd_ctrl_i.yc);
    flags.item_cut    = rsub_pkg::is_cut(hd_ctrl_i.xc, hd_ctrl_i.yc);
    flags.last_piece  = sel.last;
    flags.list_cut    = sel.last & hd_ctrl_i.list_cut;
  end

  // Emit a piece whenever a head item is waiting and the result buffer has room
  assign step      = hd_valid_i & ~o_cnt_q[1];
  assign hd_take_o = step & sel.last;
  assign o_wr      = step;
  assign o_rd      = pop_i & ~empty_o;
  assign empty_o   = (o_cnt_q == 2'd0);

  // Advance the piece counter and the result buffer control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q        <= '0;
      o_wr_ptr_q <= 1'b0;
      o_rd_ptr_q <= 1'b0;
      o_cnt_q    <= '0;
    end else begin
      if (step) begin
        k_q <= sel.last ? 2'd0 : k_q + 2'd1;
      end
      if (o_wr) begin
        o_wr_ptr_q <= ~o_wr_ptr_q;
      end
      if (o_rd) begin
        o_rd_ptr_q <= ~o_rd_ptr_q;
      end
      if (o_wr && !o_rd) begin
        o_cnt_q <= o_cnt_q + 2'd1;
      end else if (o_rd && !o_wr) begin
        o_cnt_q <= o_cnt_q - 2'd1;
      end
    end
  end

  // Hold finished pieces until taken
  always_ff @(posedge clk_i) begin
    if (o_wr) begin
      o_x[o_wr_ptr_q]     <= px;
      o_y[o_wr_ptr_q]     <= py;
      o_w[o_wr_ptr_q]     <= pw;
      o_h[o_wr_ptr_q]     <= ph;
      o_flags[o_wr_ptr_q] <= flags;
    end
  end

  assign piece_x_o      = o_x[o_rd_ptr_q];
  assign piece_y_o      = o_y[o_rd_ptr_q];
  assign piece_width_o  = o_w[o_rd_ptr_q];
  assign piece_height_o = o_h[o_rd_ptr_q];
  assign piece_valid_o  = o_flags[o_rd_ptr_q].piece_valid;
  assign item_cut_o     = o_flags[o_rd_ptr_q].item_cut;
  assign last_piece_o   = o_flags[o_rd_ptr_q].last_piece;
  assign list_cut_o     = o_flags[o_rd_ptr_q].list_cut;

endmodule

`default_nettype wire

/* rtl/rectangle_subtract.sv */
// Top level of the rectangle subtract block: clip box registers and front/back wiring.
//
// Removes the clip box B (set through the APB registers clip_x, clip_y, clip_width,
// clip_height at byte addresses 0, 4, 8, 12) from each incoming rectangle A and returns
// the leftover pieces, one result item each, last_piece marking the final one. A fully
// covered A gives one item with piece_valid low; an A that B misses comes back unchanged
// with item_cut low. list_cut is the OR of item_cut over a list and shows only on the
// last piece of the rectangle flagged end_of_list. The front end classifies one rectangle
// per cycle into a 4-entry queue while it is not full; the back end turns the queue head
// into one piece per cycle while the result buffer has room, giving 1 to 4 pieces per
// rectangle (4 when B sits strictly inside A). A pushed rectangle is registered in the
// queue and its pieces then in the 2-entry result buffer, which keeps pieces flowing at
// one per cycle while pop stays high. Write the clip registers only while the block is idle.
`default_nettype none

module rectangle_subtract #(
  parameter int unsigned COORD_WIDTH = rsub_pkg::COORD_WIDTH_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // configuration
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [rsub_pkg::APB_ADDR_WIDTH-1:0] paddr,
  input  wire logic [rsub_pkg::APB_DATA_WIDTH-1:0] pwdata,
  output logic [rsub_pkg::APB_DATA_WIDTH-1:0]      prdata,
  output logic                                     pready,
  // rectangle intake
  input  wire logic                                push,
  output logic                                     full,
  input  wire logic [COORD_WIDTH-1:0]              a_x_i,
  input  wire logic [COORD_WIDTH-1:0]              a_y_i,
  input  wire logic [COORD_WIDTH-2:0]              a_width_i,
  input  wire logic [COORD_WIDTH-2:0]              a_height_i,
  input  wire logic                                end_of_list_i,
  // pieces
  output logic                                     empty,
  input  wire logic                                pop,
  output logic [COORD_WIDTH-1:0]                   piece_x_o,
  output logic [COORD_WIDTH-1:0]                   piece_y_o,
  output logic [COORD_WIDTH-2:0]                   piece_width_o,
  output logic [COORD_WIDTH-2:0]                   piece_height_o,
  output logic                                     piece_valid_o,
  output logic                                     item_cut_o,
  output logic                                     last_piece_o,
  output logic                                     list_cut_o
);

  localparam int unsigned W  = COORD_WIDTH;
  localparam int unsigned SW = COORD_WIDTH - 1;
  localparam int unsigned DW = rsub_pkg::APB_DATA_WIDTH;

  logic [W-1:0]         clip_x_q, clip_y_q;
  logic [SW-1:0]        clip_width_q, clip_height_q;
  logic                 cfg_wr;
  logic                 hd_valid, hd_take;
  logic [W-1:0]         hd_ax0, hd_ay0;
  logic [SW-1:0]        hd_aw, hd_ah, hd_left, hd_right, hd_top, hd_bottom, hd_upper, hd_lower;
  rsub_pkg::item_ctrl_t hd_ctrl;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  // Write the clip box registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clip_x_q      <= '0;
      clip_y_q      <= '0;
      clip_width_q  <= '0;
      clip_height_q <= '0;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        rsub_pkg::REG_CLIP_X:      clip_x_q      <= pwdata[W-1:0];
        rsub_pkg::REG_CLIP_Y:      clip_y_q      <= pwdata[W-1:0];
        rsub_pkg::REG_CLIP_WIDTH:  clip_width_q  <= pwdata[SW-1:0];
        rsub_pkg::REG_CLIP_HEIGHT: clip_height_q <= pwdata[SW-1:0];
        default: ;
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    case (paddr[3:2])
      rsub_pkg::REG_CLIP_X:      prdata = DW'(clip_x_q);
      rsub_pkg::REG_CLIP_Y:      prdata = DW'(clip_y_q);
      rsub_pkg::REG_CLIP_WIDTH:  prdata = DW'(clip_width_q);
      rsub_pkg::REG_CLIP_HEIGHT: prdata = DW'(clip_height_q);
      default:                   prdata = '0;
    endcase
  end

  rsub_front #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .clip_x_i      (clip_x_q),
    .clip_y_i      (clip_y_q),
    .clip_width_i  (clip_width_q),
    .clip_height_i (clip_height_q),
    .push_i        (push),
    .full_o        (full),
    .a_x_i         (a_x_i),
    .a_y_i         (a_y_i),
    .a_width_i     (a_width_i),
    .a_height_i    (a_height_i),
    .end_of_list_i (end_of_list_i),
    .hd_valid_o    (hd_valid),
    .hd_take_i     (hd_take),
    .hd_ax0_o      (hd_ax0),
    .hd_ay0_o      (hd_ay0),
    .hd_aw_o       (hd_aw),
    .hd_ah_o       (hd_ah),
    .hd_left_o     (hd_left),
    .hd_right_o    (hd_right),
    .hd_top_o      (hd_top),
    .hd_bottom_o   (hd_bottom),
    .hd_upper_o    (hd_upper),
    .hd_lower_o    (hd_lower),
    .hd_ctrl_o     (hd_ctrl)
  );

  rsub_back #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .clip_x_i       (clip_x_q),
    .clip_y_i       (clip_y_q),
    .clip_width_i   (clip_width_q),
    .clip_height_i  (clip_height_q),
    .hd_valid_i     (hd_valid),
    .hd_take_o      (hd_take),
    .hd_ax0_i       (hd_ax0),
    .hd_ay0_i       (hd_ay0),
    .hd_aw_i        (hd_aw),
    .hd_ah_i        (hd_ah),
    .hd_left_i      (hd_left),
    .hd_right_i     (hd_right),
    .hd_top_i       (hd_top),
    .hd_bottom_i    (hd_bottom),
    .hd_upper_i     (hd_upper),
    .hd_lower_i     (hd_lower),
    .hd_ctrl_i      (hd_ctrl),
    .empty_o        (empty),
    .pop_i          (pop),
    .piece_x_o      (piece_x_o),
    .piece_y_o      (piece_y_o),
    .piece_width_o  (piece_width_o),
    .piece_height_o (piece_height_o),
    .piece_valid_o  (piece_valid_o),
    .item_cut_o     (item_cut_o),
    .last_piece_o   (last_piece_o),
    .list_cut_o     (list_cut_o)
  );

endmodule

`default_nettype wire

/* sim/rsub_checker.sv */
// Checker for the rectangle subtract block: tracks the clip box, predicts pieces, compares them.
module rsub_checker #(
  parameter int unsigned CW = rsub_pkg::COORD_WIDTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [rsub_pkg::APB_ADDR_WIDTH-1:0] paddr,
  input  logic [rsub_pkg::APB_DATA_WIDTH-1:0] pwdata,
  input  logic                                pready,
  input  logic                                push,
  input  logic                                full,
  input  logic [CW-1:0]                       a_x_i,
  input  logic [CW-1:0]                       a_y_i,
  input  logic [CW-2:0]                       a_width_i,
  input  logic [CW-2:0]                       a_height_i,
  input  logic                                end_of_list_i,
  input  logic                                empty,
  input  logic                                pop,
  input  logic [CW-1:0]                       piece_x_o,
  input  logic [CW-1:0]                       piece_y_o,
  input  logic [CW-2:0]                       piece_width_o,
  input  logic [CW-2:0]                       piece_height_o,
  input  logic                                piece_valid_o,
  input  logic                                item_cut_o,
  input  logic                                last_piece_o,
  input  logic                                list_cut_o,
  output int                                  fail_count_o,
  output int                                  pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [CW-1:0] x;
    logic [CW-1:0] y;
    logic [CW-2:0] w;
    logic [CW-2:0] h;
    logic          valid;
    logic          cut;
    logic          last;
    logic          lcut;
  } piece_t;

  // Clip box as the block should hold it
  logic [CW-1:0] clip_x;
  logic [CW-1:0] clip_y;
  logic [CW-2:0] clip_w;
  logic [CW-2:0] clip_h;
  logic          list_cut_run;

  piece_t pieces_due[$];

  // Pieces of the current rectangle, in the order they are formed
  int sx[4], sy[4], sw[4], sh[4];
  int staged;

  function automatic rsub_pkg::cls_e span_class(int a0, int a1, int b0, int b1);
    if (b0 <= a0) begin
      if (b1 <= a0) return rsub_pkg::CLS_BEFORE;
      if (b1 < a1) return rsub_pkg::CLS_LEAD;
      return rsub_pkg::CLS_COVER;
    end
    if (b0 < a1) return (b1 < a1) ? rsub_pkg::CLS_MID : rsub_pkg::CLS_TRAIL;
    return rsub_pkg::CLS_AFTER;
  endfunction

  function automatic void stage(int x, int y, int w, int h);
    sx[staged] = x;
    sy[staged] = y;
    sw[staged] = w;
    sh[staged] = h;
    staged++;
  endfunction

  // Split one rectangle against the clip box and queue the expected pieces
  function automatic void subtract_clip(logic [CW-1:0] ax, logic [CW-1:0] ay,
                                        logic [CW-2:0] aw_v, logic [CW-2:0] ah_v,
                                        logic eol);
    int ax0, ay0, aw, ah, ax1, ay1, bx0, by0, bw, bh, bx1, by1;
    rsub_pkg::cls_e xc, yc;
    logic cut, valid, last;
    piece_t p;
    ax0 = $signed(ax);
    ay0 = $signed(ay);
    aw = aw_v;
    ah = ah_v;
    bx0 = $signed(clip_x);
    by0 = $signed(clip_y);
    bw = clip_w;
    bh = clip_h;
    ax1 = ax0 + aw;
    ay1 = ay0 + ah;
    bx1 = bx0 + bw;
    by1 = by0 + bh;
    xc = span_class(ax0, ax1, bx0, bx1);
    yc = span_class(ay0, ay1, by0, by1);
    cut = 1'b1;
    valid = 1'b1;
    staged = 0;
    case ({xc, yc})
      {rsub_pkg::CLS_TRAIL, rsub_pkg::CLS_TRAIL}: begin
        stage(ax0, ay0, aw, by0 - ay0);
        stage(ax0, by0, bx0 - ax0, ay1 - by0);
      end
      {rsub_pkg::CLS_TRAIL, rsub_pkg::CLS_LEAD}: begin
        stage(ax0, ay0, bx0 - ax0, by1 - ay0);
        stage(ax0, by1, aw, ay1 - by1);
      end
      {rsub_pkg::CLS_LEAD, rsub_pkg::CLS_LEAD}: begin
        stage(bx1, ay0, ax1 - bx1, by1 - ay0);
        stage(ax0, by1, aw, ay1 - by1);
      end
      {rsub_pkg::CLS_LEAD, rsub_pkg::CLS_TRAIL}: begin
        stage(ax0, ay0, aw, by0 - ay0);
        stage(bx1, by0, ax1 - bx1, ay1 - by0);
      end
      {rsub_pkg::CLS_TRAIL, rsub_pkg::CLS_MID}: begin
        stage(ax0, ay0, aw, by0 - ay0);
        stage(ax0, by0, bx0 - ax0, bh);
        stage(ax0, by1, aw, ay1 - by1);
      end
      {rsub_pkg::CLS_MID, rsub_pkg::CLS_LEAD}: begin
        stage(ax0, ay0, bx0 - ax0, ah);
        stage(bx0, by1, bw, ay1 - by1);
        stage(bx1, ay0, ax1 - bx1, ah);
      end
      {rsub_pkg::CLS_LEAD, rsub_pkg::CLS_MID}: begin
        stage(ax0, ay0, aw, by0 - ay0);
        stage(bx1, by0, ax1 - bx1, bh);
        stage(ax0, by1, aw, ay1 - by1);
      end
      {rsub_pkg::CLS_MID, rsub_pkg::CLS_TRAIL}: begin
        stage(ax0, ay0, bx0 - ax0, ah);
        stage(bx0, ay0, bw, by0 - ay0);
        stage(bx1, ay0, ax1 - bx1, ah);
      end
      {rsub_pkg::CLS_TRAIL, rsub_pkg::CLS_COVER}: stage(ax0, ay0, bx0 - ax0, ah);
      {rsub_pkg::CLS_COVER, rsub_pkg::CLS_LEAD}:  stage(ax0, by1, aw, ay1 - by1);
      {rsub_pkg::CLS_LEAD, rsub_pkg::CLS_COVER}:  stage(bx1, ay0, ax1 - bx1, ah);
      {rsub_pkg::CLS_COVER, rsub_pkg::CLS_TRAIL}: stage(ax0, ay0, aw, by0 - ay0);
      {rsub_pkg::CLS_COVER, rsub_pkg::CLS_MID}: begin
        stage(ax0, ay0, aw, by0 - ay0);
        stage(ax0, by1, aw, ay1 - by1);
      end
      {rsub_pkg::CLS_MID, rsub_pkg::CLS_COVER}: begin
        stage(ax0, ay0, bx0 - ax0, ah);
        stage(bx1, ay0, ax1 - bx1, ah);
      end
      {rsub_pkg::CLS_COVER, rsub_pkg::CLS_COVER}: begin
        valid = 1'b0;
        stage(0, 0, 0, 0);
      end
      {rsub_pkg::CLS_MID, rsub_pkg::CLS_MID}: begin
        stage(ax0, ay0, aw, by0 - ay0);
        stage(ax0, by0, bx0 - ax0, bh);
        stage(bx1, by0, ax1 - bx1, bh);
        stage(ax0, by1, aw, ay1 - by1);
      end
      default: begin
        cut = 1'b0;
        stage(ax0, ay0, aw, ah);
      end
    endcase
    for (int k = 0; k < staged; k++) begin
      last = (k == staged - 1);
      p.x = CW'(sx[k]);
      p.y = CW'(sy[k]);
      p.w = (CW-1)'(sw[k]);
      p.h = (CW-1)'(sh[k]);
      p.valid = valid;
      p.cut = cut;
      p.last = last;
      p.lcut = last && eol && (list_cut_run || cut);
      pieces_due.push_back(p);
    end
    list_cut_run = eol ? 1'b0 : (list_cut_run || cut);
  endfunction

  function automatic void note_failure();
    fail_count_o++;
  endfunction

  // Watch the register port and both item channels
  always @(posedge clk_i or negedge rst_ni) begin
    piece_t exp_p, got_p;
    if (!rst_ni) begin
      clip_x = '0;
      clip_y = '0;
      clip_w = '0;
      clip_h = '0;
      list_cut_run = 1'b0;
      pieces_due.delete();
      fail_count_o = 0;
      pending_o = 0;
    end else begin
      // Check an accepted piece against the oldest expectation
      if (pop && !empty) begin
        got_p = '{piece_x_o, piece_y_o, piece_width_o, piece_height_o,
                  piece_valid_o, item_cut_o, last_piece_o, list_cut_o};
        if (pieces_due.size() == 0) begin
          if (fail_count_o < 10)
            $display("%0t: piece with nothing expected: x=%0d y=%0d w=%0d h=%0d", $realtime,
                     $signed(got_p.x), $signed(got_p.y), got_p.w, got_p.h);
          note_failure();
        end else begin
          exp_p = pieces_due.pop_front();
          if (got_p !== exp_p) begin
            if (fail_count_o < 10) begin
              $display("%0t: piece mismatch, expected x=%0d y=%0d w=%0d h=%0d v=%b cut=%b",
                       $realtime, $signed(exp_p.x), $signed(exp_p.y), exp_p.w, exp_p.h,
                       exp_p.valid, exp_p.cut, " last=%b lcut=%b", exp_p.last, exp_p.lcut);
              $display("    got x=%0d y=%0d w=%0d h=%0d v=%b cut=%b last=%b lcut=%b",
                       $signed(got_p.x), $signed(got_p.y), got_p.w, got_p.h,
                       got_p.valid, got_p.cut, got_p.last, got_p.lcut);
            end
            note_failure();
          end
        end
      end
      // Predict the pieces of an accepted rectangle
      if (push && !full)
        subtract_clip(a_x_i, a_y_i, a_width_i, a_height_i, end_of_list_i);
      // Track clip box writes
      if (psel && penable && pwrite && pready) begin
        case (paddr[rsub_pkg::APB_ADDR_WIDTH-1:2])
          rsub_pkg::REG_CLIP_X:      clip_x = pwdata[CW-1:0];
          rsub_pkg::REG_CLIP_Y:      clip_y = pwdata[CW-1:0];
          rsub_pkg::REG_CLIP_WIDTH:  clip_w = pwdata[CW-2:0];
          rsub_pkg::REG_CLIP_HEIGHT: clip_h = pwdata[CW-2:0];
          default: ;
        endcase
      end
      pending_o = pieces_due.size();
    end
  end

endmodule

/* sim/tb_rectangle_subtract.sv */
// Testbench top for the rectangle subtract block: clock, reset, stimulus and verdict.
module tb_rectangle_subtract;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CW = rsub_pkg::COORD_WIDTH_DEF;
  localparam int CYCLE_LIMIT = 400000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                                psel = 1'b0;
  logic                                penable = 1'b0;
  logic                                pwrite = 1'b0;
  logic [rsub_pkg::APB_ADDR_WIDTH-1:0] paddr = '0;
  logic [rsub_pkg::APB_DATA_WIDTH-1:0] pwdata = '0;
  logic [rsub_pkg::APB_DATA_WIDTH-1:0] prdata;
  logic                                pready;

  logic          push = 1'b0;
  logic          full;
  logic [CW-1:0] a_x_i = '0;
  logic [CW-1:0] a_y_i = '0;
  logic [CW-2:0] a_width_i = '0;
  logic [CW-2:0] a_height_i = '0;
  logic          end_of_list_i = 1'b0;

  logic          empty;
  logic          pop = 1'b0;
  logic [CW-1:0] piece_x_o;
  logic [CW-1:0] piece_y_o;
  logic [CW-2:0] piece_width_o;
  logic [CW-2:0] piece_height_o;
  logic          piece_valid_o;
  logic          item_cut_o;
  logic          last_piece_o;
  logic          list_cut_o;

  int fail_count;
  int pending;
  int cycle_count = 0;
  bit calm_phase = 1'b0;

  // Clip box as last written, used to aim rectangles at its edges
  int box_x = 0, box_y = 0, box_w = 0, box_h = 0;

  rectangle_subtract #(.COORD_WIDTH(CW)) u_dut (.*);

  rsub_checker #(.CW(CW)) u_checker (
    .*,
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always #4 clk_i = ~clk_i;

  // Give up on a hung block
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL rectangle_subtract");
      $finish;
    end
  end

  function automatic int draw_gap();
    if (calm_phase || $urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, 14);
  endfunction

  // Pop pieces with random stalls
  initial begin
    int gap;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      gap = draw_gap();
      if (gap != 0) begin
        pop = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      pop = 1'b1;
      @(posedge clk_i);
      while (empty) @(posedge clk_i);
    end
  end

  task automatic apb_write(logic [1:0] idx, logic [rsub_pkg::APB_DATA_WIDTH-1:0] data);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = data;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  // Write the clip box, with random junk above each field
  task automatic set_clip(int x, int y, int w, int h);
    logic [rsub_pkg::APB_DATA_WIDTH-1:0] d;
    d = $urandom;
    d[CW-1:0] = CW'(x);
    apb_write(rsub_pkg::REG_CLIP_X, d);
    d = $urandom;
    d[CW-1:0] = CW'(y);
    apb_write(rsub_pkg::REG_CLIP_Y, d);
    d = $urandom;
    d[CW-2:0] = (CW-1)'(w);
    apb_write(rsub_pkg::REG_CLIP_WIDTH, d);
    d = $urandom;
    d[CW-2:0] = (CW-1)'(h);
    apb_write(rsub_pkg::REG_CLIP_HEIGHT, d);
    box_x = $signed(CW'(x));
    box_y = $signed(CW'(y));
    box_w = (CW-1)'(w);
    box_h = (CW-1)'(h);
  endtask

  // Hold off until every expected piece is out, then let the pipeline settle
  task automatic drain();
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic send_rect(int x, int y, int w, int h, bit eol);
    int gap;
    gap = draw_gap();
    if (gap != 0) begin
      push = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    a_x_i = CW'(x);
    a_y_i = CW'(y);
    a_width_i = (CW-1)'(w);
    a_height_i = (CW-1)'(h);
    end_of_list_i = eol;
    push = 1'b1;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    @(negedge clk_i);
    push = 1'b0;
  endtask

  // Pick a span that mostly straddles the clip edges on one axis
  task automatic aim_span(int b0, int bw, output int a0, output int aw);
    if ($urandom_range(0, 9) < 7) begin
      a0 = ($urandom_range(0, 1) ? b0 : b0 + bw) + $urandom_range(0, 80) - 40;
      case ($urandom_range(0, 3))
        0:       aw = $urandom_range(0, 3);
        1:       aw = $urandom_range(0, 100);
        2:       aw = bw + $urandom_range(0, 80);
        default: aw = $urandom_range(0, 32767);
      endcase
    end else begin
      a0 = $urandom_range(0, 65535);
      aw = $urandom_range(0, 32767);
    end
  endtask

  task automatic run_random(int count);
    int x, y, w, h;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 39) == 0) drain();
      aim_span(box_x, box_w, x, w);
      aim_span(box_y, box_h, y, h);
      send_rect(x, y, w, h, $urandom_range(0, 3) == 0);
    end
  endtask

  // Stimulus
  initial begin
    // Per-axis placements against a box spanning 100..150, indexed by class
    int span_start[6] = '{200, 120, 110, 50, 50, 0};
    int span_len[6]   = '{10, 100, 20, 200, 70, 50};
    int w, h;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Reset values of the clip box: a zero-size box at the origin
    run_random(30);
    drain();

    // Every overlap case, then no overlap and the field extremes
    set_clip(100, 100, 50, 50);
    for (int i = rsub_pkg::CLS_LEAD; i <= rsub_pkg::CLS_TRAIL; i++)
      for (int j = rsub_pkg::CLS_LEAD; j <= rsub_pkg::CLS_TRAIL; j++)
        send_rect(span_start[i], span_start[j], span_len[i], span_len[j],
                  j == rsub_pkg::CLS_TRAIL);
    send_rect(span_start[rsub_pkg::CLS_BEFORE], span_start[rsub_pkg::CLS_MID],
              span_len[rsub_pkg::CLS_BEFORE], span_len[rsub_pkg::CLS_MID], 1'b0);
    send_rect(span_start[rsub_pkg::CLS_MID], span_start[rsub_pkg::CLS_AFTER],
              span_len[rsub_pkg::CLS_MID], span_len[rsub_pkg::CLS_AFTER], 1'b1);
    send_rect(-32768, -32768, 32767, 32767, 1'b0);
    send_rect(32767, 32767, 32767, 32767, 1'b1);
    send_rect(32767, -32768, 0, 0, 1'b0);
    send_rect(100, 100, 0, 0, 1'b1);
    drain();

    // Extreme boxes; the far edges of the second one wrap
    set_clip(-32768, -32768, 32767, 32767);
    run_random(50);
    drain();
    set_clip(32767, 32767, 32767, 32767);
    run_random(50);
    drain();

    // A thin box with both sides running flat out
    calm_phase = 1'b1;
    set_clip(-40, 25, 300, 7);
    run_random(50);
    drain();
    calm_phase = 1'b0;

    // Random boxes
    for (int r = 0; r < 3; r++) begin
      w = (r == 2) ? $urandom_range(0, 32767) : $urandom_range(0, 400);
      h = (r == 2) ? $urandom_range(0, 32767) : $urandom_range(0, 400);
      set_clip($urandom_range(0, 65535), $urandom_range(0, 65535), w, h);
      run_random(50);
      drain();
    end

    repeat (20) @(negedge clk_i);
    if (fail_count == 0)
      $display("PASS rectangle_subtract");
    else
      $display("FAIL rectangle_subtract");
    $finish;
  end

endmodule
